// ===== src/sorted_key_code_table_defines.svh =====
// Assertion macros for the sorted key code table.
`ifndef SORTED_KEY_CODE_TABLE_DEFINES_SVH
`define SORTED_KEY_CODE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle
`define SKCT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skct assertion failed");
// Antecedent implies consequent in the next cycle
`define SKCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skct assertion failed");
`else
`define SKCT_ASSERT_SAME(lbl, ante, cons)
`define SKCT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/skct_pkg.sv =====
// Shared constants, codes and controller/datapath command types.
package skct_pkg;

  localparam int KEY_W            = 16;
  localparam int CODE_W           = 7;
  localparam int STATUS_W         = 3;
  localparam int COUNT_W          = 8;
  localparam int DEFAULT_CAPACITY = 128;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_UPDATED  = 3'd2,
    ST_INSERTED = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_NOCHANGE = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

  // Request types
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_SET    = 1'b1;

  // Read address select
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_PREV,
    RD_FILLM1
  } rd_sel_t;

  // Index register update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_FILLM1
  } idx_op_t;

  // Write address select
  typedef enum logic [1:0] {
    WR_IDX,
    WR_PREV,
    WR_NEXT,
    WR_POS
  } wr_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    latch_req;
    rd_sel_t rd_sel;
    idx_op_t idx_op;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    wr_new;
    logic    cap_code;
    logic    pos_load;
    logic    fill_inc;
    logic    fill_dec;
    logic    load_out;
    status_t status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eq;
    logic ge;
    logic last;
    logic idx_at_fill;
    logic idx_at_pos;
    logic src_lt_fill;
    logic full;
    logic fill_zero;
    logic code_zero;
    logic req_set;
    logic out_busy;
  } sts_t;

endpackage

// ===== src/skct_if.sv =====
// Request and result channel interfaces.
interface skct_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [skct_pkg::KEY_W-1:0]  key;
  logic [skct_pkg::CODE_W-1:0] code_in;

  modport source (output valid, req_type, key, code_in, input ready);
  modport sink   (input valid, req_type, key, code_in, output ready);
endinterface

interface skct_out_if;
  logic                          valid;
  logic                          ready;
  logic [skct_pkg::CODE_W-1:0]   code_out;
  logic [skct_pkg::STATUS_W-1:0] status;
  logic [skct_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, code_out, status, entry_count, input ready);
  modport sink   (input valid, code_out, status, entry_count, output ready);
endinterface

// ===== src/skct_dp.sv =====
// Datapath: entry memory, scan index, fill count and result register.
module skct_dp #(
  parameter int CAPACITY = skct_pkg::DEFAULT_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_req_type,
  input  logic [skct_pkg::KEY_W-1:0]    in_key,
  input  logic [skct_pkg::CODE_W-1:0]   in_code,
  input  skct_pkg::cmd_t                cmd,
  output skct_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [skct_pkg::CODE_W-1:0]   out_code,
  output logic [skct_pkg::STATUS_W-1:0] out_status,
  output logic [skct_pkg::COUNT_W-1:0]  out_count
);

  localparam int CW      = $clog2(CAPACITY + 1);
  localparam int AW      = $clog2(CAPACITY);
  localparam int ENTRY_W = skct_pkg::KEY_W + skct_pkg::CODE_W;

  logic [ENTRY_W-1:0] mem [CAPACITY];
  logic [ENTRY_W-1:0] rd_data_r;

  logic                        req_type_r;
  logic [skct_pkg::KEY_W-1:0]  key_r;
  logic [skct_pkg::CODE_W-1:0] code_r;
  logic [skct_pkg::CODE_W-1:0] found_code_r;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [CW-1:0]               pos_r;
  logic [CW-1:0]               fill_r, fill_nxt;

  logic                          out_valid_r;
  logic [skct_pkg::CODE_W-1:0]   out_code_r;
  logic [skct_pkg::STATUS_W-1:0] out_status_r;
  logic [skct_pkg::COUNT_W-1:0]  out_count_r;

  logic [CW-1:0]                idx_inc, idx_dec, fill_m1;
  logic [CW-1:0]                rd_addr_w, wr_addr_w;
  logic [ENTRY_W-1:0]           wr_data;
  logic [skct_pkg::KEY_W-1:0]   rd_key;
  logic [skct_pkg::CODE_W-1:0]  rd_code;

  assign idx_inc = idx_r + CW'(1);
  assign idx_dec = idx_r - CW'(1);
  assign fill_m1 = fill_r - CW'(1);
  assign rd_key  = rd_data_r[ENTRY_W-1 -: skct_pkg::KEY_W];
  assign rd_code = rd_data_r[skct_pkg::CODE_W-1:0];

  // Address and data selection
  always_comb begin
    case (cmd.rd_sel)
      skct_pkg::RD_ZERO:   rd_addr_w = '0;
      skct_pkg::RD_NEXT:   rd_addr_w = idx_inc;
      skct_pkg::RD_PREV:   rd_addr_w = idx_dec;
      skct_pkg::RD_FILLM1: rd_addr_w = fill_m1;
      default:             rd_addr_w = '0;
    endcase
    case (cmd.wr_sel)
      skct_pkg::WR_IDX:  wr_addr_w = idx_r;
      skct_pkg::WR_PREV: wr_addr_w = idx_dec;
      skct_pkg::WR_NEXT: wr_addr_w = idx_inc;
      skct_pkg::WR_POS:  wr_addr_w = pos_r;
      default:           wr_addr_w = idx_r;
    endcase
    wr_data = cmd.wr_new ? {key_r, code_r} : rd_data_r;
  end

  // Index and fill count updates
  always_comb begin
    case (cmd.idx_op)
      skct_pkg::IDX_HOLD:   idx_nxt = idx_r;
      skct_pkg::IDX_ZERO:   idx_nxt = '0;
      skct_pkg::IDX_INC:    idx_nxt = idx_inc;
      skct_pkg::IDX_DEC:    idx_nxt = idx_dec;
      skct_pkg::IDX_FILLM1: idx_nxt = fill_m1;
      default:              idx_nxt = idx_r;
    endcase
    fill_nxt = fill_r;
    if (cmd.fill_inc) begin
      fill_nxt = fill_r + CW'(1);
    end else if (cmd.fill_dec) begin
      fill_nxt = fill_m1;
    end
  end

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr_w[AW-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr_w[AW-1:0]];
  end

  // Request latch and scan registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_type_r <= in_req_type;
      key_r      <= in_key;
      code_r     <= in_code;
    end
    if (cmd.cap_code) begin
      found_code_r <= rd_code;
    end
    if (cmd.pos_load) begin
      pos_r <= idx_r;
    end
    idx_r <= idx_nxt;
  end

  // Fill count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_code_r   <= (cmd.status == skct_pkg::ST_HIT) ? found_code_r : '0;
      out_status_r <= cmd.status;
      out_count_r  <= skct_pkg::COUNT_W'(fill_r);
    end
  end

  // Status toward the controller
  always_comb begin
    sts.eq          = (rd_key == key_r);
    sts.ge          = (rd_key >= key_r);
    sts.last        = (idx_inc == fill_r);
    sts.idx_at_fill = (idx_r == fill_r);
    sts.idx_at_pos  = (idx_r == pos_r);
    sts.src_lt_fill = (idx_r < fill_r);
    sts.full        = (fill_r == CW'(CAPACITY));
    sts.fill_zero   = (fill_r == '0);
    sts.code_zero   = (code_r == '0);
    sts.req_set     = (req_type_r == skct_pkg::REQ_SET);
    sts.out_busy    = out_valid_r && !out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_code   = out_code_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

// ===== src/skct_ctrl.sv =====
// Controller: sequences scan, decision, shift and result for one request.
module skct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  skct_pkg::sts_t sts,
  output skct_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHDN,
    S_SHUP,
    S_WNEW,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic              found_r, found_nxt;
  skct_pkg::status_t status_r, status_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    found_nxt    = found_r;
    status_nxt   = status_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = skct_pkg::RD_NEXT;
    cmd.idx_op   = skct_pkg::IDX_HOLD;
    cmd.wr_sel   = skct_pkg::WR_IDX;
    cmd.status   = status_r;
    case (state_r)
      S_IDLE: begin
        // no transaction is taken while reset is held
        in_ready = rst_n;
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          cmd.rd_sel    = skct_pkg::RD_ZERO;
          cmd.idx_op    = skct_pkg::IDX_ZERO;
          found_nxt     = 1'b0;
          state_nxt     = sts.fill_zero ? S_ACT : S_SCAN;
        end
      end
      // one entry compared per cycle, next read already issued
      S_SCAN: begin
        cmd.rd_sel = skct_pkg::RD_NEXT;
        if (sts.ge) begin
          found_nxt    = sts.eq;
          cmd.cap_code = 1'b1;
          state_nxt    = S_ACT;
        end else begin
          cmd.idx_op = skct_pkg::IDX_INC;
          if (sts.last) begin
            found_nxt = 1'b0;
            state_nxt = S_ACT;
          end
        end
      end
      S_ACT: begin
        state_nxt = S_FIN;
        if (!sts.req_set) begin
          status_nxt = found_r ? skct_pkg::ST_HIT : skct_pkg::ST_MISS;
        end else if (found_r) begin
          if (!sts.code_zero) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = skct_pkg::WR_IDX;
            cmd.wr_new = 1'b1;
            status_nxt = skct_pkg::ST_UPDATED;
          end else begin
            cmd.idx_op = skct_pkg::IDX_INC;
            cmd.rd_sel = skct_pkg::RD_NEXT;
            status_nxt = skct_pkg::ST_REMOVED;
            state_nxt  = S_SHDN;
          end
        end else if (sts.code_zero) begin
          status_nxt = skct_pkg::ST_NOCHANGE;
        end else if (sts.full) begin
          status_nxt = skct_pkg::ST_FULL;
        end else begin
          status_nxt   = skct_pkg::ST_INSERTED;
          cmd.pos_load = 1'b1;
          if (sts.idx_at_fill) begin
            state_nxt = S_WNEW;
          end else begin
            cmd.idx_op = skct_pkg::IDX_FILLM1;
            cmd.rd_sel = skct_pkg::RD_FILLM1;
            state_nxt  = S_SHUP;
          end
        end
      end
      // remove: copy entry idx down to idx-1 until the end of the table
      S_SHDN: begin
        if (sts.src_lt_fill) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = skct_pkg::WR_PREV;
          cmd.idx_op = skct_pkg::IDX_INC;
          cmd.rd_sel = skct_pkg::RD_NEXT;
        end else begin
          cmd.fill_dec = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      // insert: copy entry idx up to idx+1, from the top down to the slot
      S_SHUP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = skct_pkg::WR_NEXT;
        if (sts.idx_at_pos) begin
          state_nxt = S_WNEW;
        end else begin
          cmd.idx_op = skct_pkg::IDX_DEC;
          cmd.rd_sel = skct_pkg::RD_PREV;
        end
      end
      S_WNEW: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = skct_pkg::WR_POS;
        cmd.wr_new   = 1'b1;
        cmd.fill_inc = 1'b1;
        state_nxt    = S_FIN;
      end
      // wait for the result register to be free
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      found_r  <= 1'b0;
      status_r <= skct_pkg::ST_HIT;
    end else begin
      state_r  <= state_nxt;
      found_r  <= found_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== src/sorted_key_code_table.sv =====
// Top level of the sorted key code table.
//
// Holds up to CAPACITY key/code pairs in ascending key order in a single-port-write,
// single-port-read memory. One request is handled at a time. A request scans
// the entries from the bottom at one entry per cycle until it reaches a key
// at or above the requested one, then acts: a lookup or an update finishes at
// once, a removal shifts the later entries down and an insertion shifts them
// up, one entry per cycle through the memory's read and write ports. Scan plus
// shift cover the table at most once. The next request is accepted in the
// cycle after the result is loaded. The result sits in an output register, so
// the next request is accepted while it waits; a request only stalls at its
// end while the previous result is still held. Input ready stays low during
// reset. After reset the table is empty; no clearing pass is needed.
`include "sorted_key_code_table_defines.svh"

module sorted_key_code_table #(
  parameter int CAPACITY = skct_pkg::DEFAULT_CAPACITY
) (
  input logic              clk,
  input logic              rst_n,
  skct_in_if.sink          in_ch,
  skct_out_if.source       out_ch
);

  skct_pkg::cmd_t cmd;
  skct_pkg::sts_t sts;
  logic           in_ready;

  skct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skct_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req_type (in_ch.req_type),
    .in_key      (in_ch.key),
    .in_code     (in_ch.code_in),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_code    (out_ch.code_out),
    .out_status  (out_ch.status),
    .out_count   (out_ch.entry_count)
  );

  assign in_ch.ready = in_ready;

  // Checks
  `SKCT_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `SKCT_ASSERT_SAME(a_no_write_when_idle, cmd.wr_en, !in_ch.ready)
  `SKCT_ASSERT_SAME(a_no_result_overwrite, cmd.load_out, !(out_ch.valid && !out_ch.ready))

endmodule
